FILE: rtl/core/hcw_pkg.sv
// Shared constants, payload types and helper functions for the hue/chroma color wheel.
// Used by every module of the block; has no dependencies of its own.
package hcw_pkg;

  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 8;

  localparam int CHROMA_FRAC = 12;
  localparam int CHROMA_W    = CHROMA_FRAC + 1;
  localparam int CHROMA_ONE  = 1 << CHROMA_FRAC;
  localparam int SQRT_STEPS  = CHROMA_FRAC;
  localparam int RAD_W       = 2 * SQRT_STEPS;
  localparam int REM_W       = SQRT_STEPS + 2;
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int RAD_SHIFT   = 2 * CHROMA_FRAC + 2 - 2 * COORD_BITS;
  localparam int WIDE_W      = (SQ_W > RAD_W + 2) ? SQ_W : RAD_W + 2;

  localparam int CORDIC_STEPS = 16;
  localparam int PRE_SHIFT    = 16;
  localparam int CW           = COORD_BITS + 19;
  localparam int ZW           = 21;
  localparam int HUE_TURN     = 393216;
  localparam int HUE_HALF     = 196608;
  localparam int HUE_DROP     = 4;
  localparam int HUE_FRAC     = 12;
  localparam int HUE_W        = HUE_FRAC + 3;

  localparam int MIX_W     = 2 * CHROMA_FRAC + 1;
  localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;

  localparam int ST_SQ      = 0;
  localparam int ST_RAD     = 1;
  localparam int ST_SQRT0   = 2;
  localparam int ST_ROOT    = ST_SQRT0 + SQRT_STEPS - 1;
  localparam int ST_CORDIC0 = 1;
  localparam int ST_HUE     = ST_CORDIC0 + CORDIC_STEPS;
  localparam int ROOT_DLY   = ST_HUE - ST_ROOT;
  localparam int ST_PROD    = ST_HUE + 1;
  localparam int ST_SEL     = ST_HUE + 2;
  localparam int ST_OUT     = ST_HUE + 3;
  localparam int NSTAGES    = ST_HUE + 4;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP,
    SEC_GREEN_RED_DOWN,
    SEC_GREEN_BLUE_UP,
    SEC_BLUE_GREEN_DOWN,
    SEC_BLUE_RED_UP,
    SEC_RED_BLUE_DOWN
  } sector_t;

  typedef logic [NSTAGES-1:0] stage_en_t;

  // Offset from the centre, as a signed value of the same width.
  function automatic logic signed [COORD_BITS-1:0] coord_delta(input logic [COORD_BITS-1:0] c);
    return {~c[COORD_BITS-1], c[COORD_BITS-2:0]};
  endfunction

  // Arctangent of 2^-i in hue units, 6.0 per turn, 16 fraction bits.
  function automatic logic signed [ZW-1:0] hue_atan(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(49152);
      1:       v = ZW'(29016);
      2:       v = ZW'(15331);
      3:       v = ZW'(7782);
      4:       v = ZW'(3906);
      5:       v = ZW'(1955);
      6:       v = ZW'(978);
      7:       v = ZW'(489);
      8:       v = ZW'(244);
      9:       v = ZW'(122);
      10:      v = ZW'(61);
      11:      v = ZW'(31);
      12:      v = ZW'(15);
      13:      v = ZW'(8);
      14:      v = ZW'(4);
      15:      v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/hcw_radius.sv
// Chroma path: squares the centred coordinates and takes a bit-per-stage square root.
// Depends on hcw_pkg; stage enables come from the top-level valid chain.
module hcw_radius import hcw_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  coord_t              pix,
  output logic [CHROMA_W-1:0] chroma
);

  logic signed [COORD_BITS-1:0] dx;
  logic signed [COORD_BITS-1:0] dy;
  logic signed [SQ_W-1:0]       mx;
  logic signed [SQ_W-1:0]       my;
  logic [SQ_W-1:0]              sqx;
  logic [SQ_W-1:0]              sqy;
  logic [SQ_W-1:0]              dist2;
  logic [WIDE_W-1:0]            wide;
  logic [RAD_W-1:0]             rad;
  logic                         sat;

  logic [RAD_W-1:0]      rb_q   [SQRT_STEPS];
  logic [REM_W-1:0]      rem_q  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] root_q [SQRT_STEPS];
  logic                  sat_q  [SQRT_STEPS];
  logic [CHROMA_W-1:0]   c_q    [ROOT_DLY];

  assign dx = coord_delta(pix.x);
  assign dy = coord_delta(pix.y);
  assign mx = SQ_W'(dx) * SQ_W'(dx);
  assign my = SQ_W'(dy) * SQ_W'(dy);

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      sqx <= mx;
      sqy <= my;
    end
  end

  assign dist2 = sqx + sqy;

  if (RAD_SHIFT >= 0) begin : g_up
    assign wide = WIDE_W'(dist2) << RAD_SHIFT;
  end else begin : g_down
    assign wide = WIDE_W'(dist2 >> (-RAD_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (en[ST_RAD]) begin
      rad <= wide[RAD_W-1:0];
      sat <= |wide[WIDE_W-1:RAD_W];
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [RAD_W-1:0]      rb_prev;
    logic [REM_W-1:0]      rem_prev;
    logic [SQRT_STEPS-1:0] root_prev;
    logic                  sat_prev;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      sub;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rb_prev   = rad;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign sat_prev  = sat;
    end else begin : g_next
      assign rb_prev   = rb_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign sat_prev  = sat_q[k-1];
    end

    assign trial = {rem_prev, rb_prev[RAD_W-1 -: 2]};
    assign sub   = (REM_W + 2)'({root_prev, 2'b01});
    assign ge    = (trial >= sub);

    always_ff @(posedge clk) begin
      if (en[ST_SQRT0+k]) begin
        rb_q[k]   <= rb_prev << 2;
        rem_q[k]  <= ge ? REM_W'(trial - sub) : REM_W'(trial);
        root_q[k] <= {root_prev[SQRT_STEPS-2:0], ge};
        sat_q[k]  <= sat_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_ROOT+1]) begin
      c_q[0] <= sat_q[SQRT_STEPS-1] ? CHROMA_W'(CHROMA_ONE) : {1'b0, root_q[SQRT_STEPS-1]};
    end
  end

  for (genvar d = 1; d < ROOT_DLY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[ST_ROOT+1+d]) begin
        c_q[d] <= c_q[d-1];
      end
    end
  end

  assign chroma = c_q[ROOT_DLY-1];

endmodule

FILE: rtl/core/hcw_angle.sv
// Hue path: half-turn pre-rotation, pipelined vectoring CORDIC and wrap into one turn.
// Depends on hcw_pkg for widths and the arctangent table.
module hcw_angle import hcw_pkg::*; (
  input  logic             clk,
  input  stage_en_t        en,
  input  coord_t           pix,
  output logic [HUE_W-1:0] hue
);

  logic signed [COORD_BITS-1:0] dx;
  logic signed [COORD_BITS-1:0] dy;
  logic signed [CW-1:0]         dxe;
  logic signed [CW-1:0]         dye;
  logic                         neg;

  logic signed [CW-1:0] px_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] py_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q  [CORDIC_STEPS+1];

  logic signed [ZW-1:0] zl;
  logic signed [ZW-1:0] zw;

  assign dx  = coord_delta(pix.x);
  assign dy  = coord_delta(pix.y);
  assign dxe = CW'(dx);
  assign dye = CW'(dy);
  assign neg = dx[COORD_BITS-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_q[0] <= (neg ? -dxe : dxe) <<< PRE_SHIFT;
      py_q[0] <= (neg ? -dye : dye) <<< PRE_SHIFT;
      z_q[0]  <= neg ? ZW'(HUE_HALF) : '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = px_q[k] >>> k;
    assign ys = py_q[k] >>> k;

    always_ff @(posedge clk) begin
      if (en[ST_CORDIC0+k]) begin
        if (!py_q[k][CW-1]) begin
          px_q[k+1] <= px_q[k] + ys;
          py_q[k+1] <= py_q[k] - xs;
          z_q[k+1]  <= z_q[k] + hue_atan(k);
        end else begin
          px_q[k+1] <= px_q[k] - ys;
          py_q[k+1] <= py_q[k] + xs;
          z_q[k+1]  <= z_q[k] - hue_atan(k);
        end
      end
    end
  end

  assign zl = z_q[CORDIC_STEPS];

  always_comb begin
    if (zl < 0) begin
      zw = zl + ZW'(HUE_TURN);
    end else if (zl >= ZW'(HUE_TURN)) begin
      zw = zl - ZW'(HUE_TURN);
    end else begin
      zw = zl;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_HUE]) begin
      hue <= zw[HUE_W+HUE_DROP-1:HUE_DROP];
    end
  end

endmodule

FILE: rtl/core/hcw_mix.sv
// Color mix: forms the dominant, weakest and ramped channels per hue sector and scales them.
// Depends on hcw_pkg; takes chroma and hue aligned on the same pipeline stage.
module hcw_mix import hcw_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [CHROMA_W-1:0] chroma,
  input  logic [HUE_W-1:0]    hue,
  output rgb_t                rgb
);

  localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(1) << (MIX_W - 1);

  logic [CHROMA_W-1:0] inv_c;
  logic [MIX_W-1:0]    prod_q;
  logic [MIX_W-1:0]    low_q;
  sector_t             sector_q;
  logic [MIX_W-1:0]    up;
  logic [MIX_W-1:0]    down;
  logic [MIX_W-1:0]    r_q;
  logic [MIX_W-1:0]    g_q;
  logic [MIX_W-1:0]    b_q;

  function automatic logic [COLOR_BITS-1:0] to_channel(input logic [MIX_W-1:0] v);
    logic [MIX_W+COLOR_BITS-1:0] p;
    p = {{COLOR_BITS{1'b0}}, v} * (MIX_W + COLOR_BITS)'(COLOR_MAX);
    return p[MIX_W-1 +: COLOR_BITS];
  endfunction

  assign inv_c = CHROMA_W'(CHROMA_ONE) - chroma;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      prod_q   <= MIX_W'(chroma) * MIX_W'(hue[HUE_FRAC-1:0]);
      low_q    <= {inv_c, {CHROMA_FRAC{1'b0}}};
      sector_q <= sector_t'(hue[HUE_W-1:HUE_FRAC]);
    end
  end

  assign up   = low_q + prod_q;
  assign down = MIX_ONE - prod_q;

  always_ff @(posedge clk) begin
    if (en[ST_SEL]) begin
      unique case (sector_q)
        SEC_RED_GREEN_UP: begin
          r_q <= MIX_ONE; g_q <= up;      b_q <= low_q;
        end
        SEC_GREEN_RED_DOWN: begin
          r_q <= down;    g_q <= MIX_ONE; b_q <= low_q;
        end
        SEC_GREEN_BLUE_UP: begin
          r_q <= low_q;   g_q <= MIX_ONE; b_q <= up;
        end
        SEC_BLUE_GREEN_DOWN: begin
          r_q <= low_q;   g_q <= down;    b_q <= MIX_ONE;
        end
        SEC_BLUE_RED_UP: begin
          r_q <= up;      g_q <= low_q;   b_q <= MIX_ONE;
        end
        default: begin
          r_q <= MIX_ONE; g_q <= low_q;   b_q <= down;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      rgb.red   <= to_channel(r_q);
      rgb.green <= to_channel(g_q);
      rgb.blue  <= to_channel(b_q);
    end
  end

endmodule

FILE: rtl/core/polar_hue_chroma_to_rgb.sv
// Top level of the hue/chroma color wheel: stage valid chain, stall control, datapaths.
// Depends on hcw_pkg, hcw_radius, hcw_angle and hcw_mix.
//
// Usage: each request on the pix channel carries one pixel coordinate pair (x, y),
// centred at mid-range. For each request exactly one color appears on the rgb
// channel, in request order. Both channels use valid/ready.
// Throughput is one request per cycle unless the receiver stalls a full pipeline. The pipeline
// has 21 register stages, set by the input stage, the 16 CORDIC iterations of the hue path,
// the wrap and three mixing stages.
// The chroma square root runs one result bit per stage alongside the CORDIC and
// its result is delayed to meet the hue.
// Reset empties all stages; no output is presented until new requests arrive.
// When the receiver stalls, each stage holds its item only while the stage after
// it is also full, so empty slots are filled and pix_ready stays high until
// every stage holds an item.
module polar_hue_chroma_to_rgb import hcw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pix_valid,
  output logic   pix_ready,
  input  coord_t pix,
  output logic   rgb_valid,
  input  logic   rgb_ready,
  output rgb_t   rgb
);

  stage_en_t           vld;
  stage_en_t           en;
  logic [CHROMA_W-1:0] chroma;
  logic [HUE_W-1:0]    hue;

  always_comb begin
    for (int s = 0; s < NSTAGES; s++) begin
      en[s] = rgb_ready || !(&(vld | ((NSTAGES'(1) << s) - NSTAGES'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_valid;
      end
      for (int s = 1; s < NSTAGES; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign pix_ready = en[0];
  assign rgb_valid = vld[NSTAGES-1];

  hcw_radius u_radius (
    .clk    (clk),
    .en     (en),
    .pix    (pix),
    .chroma (chroma)
  );

  hcw_angle u_angle (
    .clk (clk),
    .en  (en),
    .pix (pix),
    .hue (hue)
  );

  hcw_mix u_mix (
    .clk    (clk),
    .en     (en),
    .chroma (chroma),
    .hue    (hue),
    .rgb    (rgb)
  );

`ifndef SYNTH
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> ((&vld) && !rgb_ready))
    else $error("request refused while the pipeline has room");

  a_item_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(vld) == $past($countones(vld))
      + ($past(pix_valid && pix_ready) ? 1 : 0)
      - ($past(rgb_valid && rgb_ready) ? 1 : 0)))
    else $error("pipeline item count lost or duplicated an item");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for polar_hue_chroma_to_rgb: directed corner pixels, then random pixels
// under changing idle and stall patterns, checked against a bit-accurate color-wheel predictor.
// Depends on hcw_pkg and the polar_hue_chroma_to_rgb RTL.
module testbench;
  import hcw_pkg::*;

  localparam int LIMIT        = 3000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 60;
  localparam int PHASE_ITEMS  = 120;
  localparam int TAIL_CYCLES  = 40;
  localparam int CENTER       = 1 << (COORD_BITS - 1);
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

  typedef struct {
    coord_t pix;
    bit     known;
    rgb_t   rgb;
  } pixel_row_t;

  localparam longint ATAN_HUE [CORDIC_STEPS] = '{
    49152, 29016, 15331, 7782, 3906, 1955, 978, 489,
    244, 122, 61, 31, 15, 8, 4, 2
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pix_valid = 1'b0;
  logic   pix_ready;
  coord_t pix = '0;
  logic   rgb_valid;
  logic   rgb_ready = 1'b0;
  rgb_t   rgb;

  rgb_t expected_rgb[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   pix_count = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_done = 1'b0;

  polar_hue_chroma_to_rgb DUT (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .rgb_valid(rgb_valid),
    .rgb_ready(rgb_ready),
    .rgb(rgb)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [COLOR_BITS-1:0] channel(longint unsigned v);
    longint unsigned cmax;
    cmax = longint'(COLOR_MAX);
    return COLOR_BITS'(((v * cmax) >> 24) & cmax);
  endfunction

  function automatic rgb_t wheel_color(coord_t p);
    longint dx, dy, px, py, nx, ny, z;
    longint unsigned d2, c, h, f, one, low, up, down, r, g, b;
    rgb_t res;
    dx = longint'(p.x) - CENTER;
    dy = longint'(p.y) - CENTER;
    d2 = longint'(dx * dx + dy * dy);
    c = root64(d2 << 24) >> (COORD_BITS - 1);
    if (c > CHROMA_ONE) c = CHROMA_ONE;
    if (dx < 0) begin
      px = -dx * 65536;
      py = -dy * 65536;
      z = HUE_HALF;
    end else begin
      px = dx * 65536;
      py = dy * 65536;
      z = 0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (py >= 0) begin
        nx = px + (py >>> i);
        ny = py - (px >>> i);
        z = z + ATAN_HUE[i];
      end else begin
        nx = px - (py >>> i);
        ny = py + (px >>> i);
        z = z - ATAN_HUE[i];
      end
      px = nx;
      py = ny;
    end
    while (z < 0) z = z + HUE_TURN;
    while (z >= HUE_TURN) z = z - HUE_TURN;
    h = z >> 4;
    f = h & 4095;
    one = 64'd1 << 24;
    low = (CHROMA_ONE - c) << 12;
    up = low + c * f;
    down = one - c * f;
    case (sector_t'(3'(h >> 12)))
      SEC_RED_GREEN_UP: begin
        r = one; g = up; b = low;
      end
      SEC_GREEN_RED_DOWN: begin
        r = down; g = one; b = low;
      end
      SEC_GREEN_BLUE_UP: begin
        r = low; g = one; b = up;
      end
      SEC_BLUE_GREEN_DOWN: begin
        r = low; g = down; b = one;
      end
      SEC_BLUE_RED_UP: begin
        r = up; g = low; b = one;
      end
      default: begin
        r = one; g = low; b = down;
      end
    endcase
    res.red = channel(r);
    res.green = channel(g);
    res.blue = channel(b);
    return res;
  endfunction

  function automatic coord_t pick_pixel();
    coord_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.x = COORD_BITS'($urandom);
    p.y = COORD_BITS'($urandom);
    if (mode < 2) begin
      p.x = COORD_BITS'(CENTER - 8 + $urandom_range(0, 16));
      p.y = COORD_BITS'(CENTER - 8 + $urandom_range(0, 16));
    end else if (mode == 2) begin
      p.y = COORD_BITS'(CENTER);
    end else if (mode == 3) begin
      p.x = COORD_BITS'(CENTER);
    end else if (mode == 4) begin
      p.y = ($urandom_range(0, 1) != 0) ? p.x : COORD_BITS'(COORD_MAX) - p.x;
    end
    return p;
  endfunction

  task automatic send(coord_t c, rgb_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= c;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    expected_rgb.push_back(want);
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
  endtask

  // The receiver stalls at random, and once holds off long enough for the pipeline to fill.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && pix_count >= HOLD_AT) begin
        hold_done = 1'b1;
        rgb_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rgb_ready <= ($urandom_range(0, 99) >= recv_stall);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (pix_valid && pix_ready) begin
        pix_count <= pix_count + 1;
      end
      if (rgb_valid && rgb_ready) begin
        if (expected_rgb.size() == 0) begin
          $error("rgb: result with no request outstanding (%0d %0d %0d)",
                 rgb.red, rgb.green, rgb.blue);
          errors++;
        end else begin
          want = expected_rgb.pop_front();
          if (rgb.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, rgb.red);
            errors++;
          end
          if (rgb.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, rgb.green);
            errors++;
          end
          if (rgb.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
            errors++;
          end
        end
      end
      if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= LIMIT) begin
        $display("polar_hue_chroma_to_rgb: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    pixel_row_t rows[$];
    coord_t     c;
    int         idle_mix[4];
    int         stall_mix[4];
    idle_mix  = '{0, 56, 0, 34};
    stall_mix = '{0, 0, 56, 34};
    rows = '{
      '{'{x: 10'd512,  y: 10'd512},  1'b1, '{red: 8'd255, green: 8'd255, blue: 8'd255}},
      '{'{x: 10'd0,    y: 10'd0},    1'b0, '0},
      '{'{x: 10'd1023, y: 10'd1023}, 1'b0, '0},
      '{'{x: 10'd0,    y: 10'd1023}, 1'b0, '0},
      '{'{x: 10'd1023, y: 10'd0},    1'b0, '0},
      '{'{x: 10'd1023, y: 10'd512},  1'b0, '0},
      '{'{x: 10'd0,    y: 10'd512},  1'b0, '0},
      '{'{x: 10'd512,  y: 10'd0},    1'b0, '0},
      '{'{x: 10'd512,  y: 10'd1023}, 1'b0, '0},
      '{'{x: 10'd513,  y: 10'd512},  1'b0, '0},
      '{'{x: 10'd511,  y: 10'd512},  1'b0, '0},
      '{'{x: 10'd512,  y: 10'd513},  1'b0, '0},
      '{'{x: 10'd512,  y: 10'd511},  1'b0, '0},
      '{'{x: 10'd800,  y: 10'd600},  1'b0, '0},
      '{'{x: 10'd600,  y: 10'd800},  1'b0, '0},
      '{'{x: 10'd300,  y: 10'd800},  1'b0, '0},
      '{'{x: 10'd200,  y: 10'd400},  1'b0, '0},
      '{'{x: 10'd400,  y: 10'd150},  1'b0, '0},
      '{'{x: 10'd750,  y: 10'd300},  1'b0, '0},
      '{'{x: 10'd1023, y: 10'd511},  1'b0, '0},
      '{'{x: 10'd767,  y: 10'd767},  1'b0, '0},
      '{'{x: 10'd1,    y: 10'd1022}, 1'b0, '0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send(rows[i].pix, rows[i].known ? rows[i].rgb : wheel_color(rows[i].pix));
    end
    for (int ph = 0; ph < 4; ph++) begin
      // Every phase starts from an empty pipeline so that the new pattern shows up cleanly.
      drain();
      send_idle = idle_mix[ph];
      recv_stall = stall_mix[ph];
      repeat (PHASE_ITEMS) begin
        c = pick_pixel();
        send(c, wheel_color(c));
      end
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("polar_hue_chroma_to_rgb: match");
    end else begin
      $display("polar_hue_chroma_to_rgb: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/hcw_pkg.sv
rtl/core/hcw_radius.sv
rtl/core/hcw_angle.sv
rtl/core/hcw_mix.sv
rtl/core/polar_hue_chroma_to_rgb.sv
dv/testbench.sv
